/* rtl/core/aled_pkg.sv */
// Shared types and constants of the addressable LED bit serializer.
package aled_pkg;

   localparam int BITS_PER_LED = 24;
   localparam int BIT_W        = 5;
   localparam int TICK_W       = 16;
   localparam int HIGH_W       = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [BITS_PER_LED-1:0] COLOR_RESET      = 24'h00A000;
   localparam logic [BIT_W-1:0]        BIT_FIRST        = 5'd23;
   localparam logic [TICK_W-1:0]       PERIOD_RESET     = 16'd89;
   localparam logic [HIGH_W-1:0]       HIGH_ONE_RESET   = 8'd71;
   localparam logic [HIGH_W-1:0]       HIGH_ZERO_RESET  = 8'd17;
   localparam logic [HIGH_W-1:0]       RESET_SLOTS_INIT = 8'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERIOD      = 2'd0,
      CSR_HIGH_ONE    = 2'd1,
      CSR_HIGH_ZERO   = 2'd2,
      CSR_RESET_SLOTS = 2'd3
   } csr_index_type;

endpackage

/* rtl/core/aled_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module aled_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/addressable_led_bit_serializer.sv */
// Top level of the addressable LED bit serializer.
//
// Every item on the req_ channel is one tick of the line waveform; with
// req_cmd high it also writes req_color into LED req_led_index (indexes at
// or above LED_TOTAL are dropped). Each item gives exactly one rsp_ item
// with the line level, slot start and frame start flags of that tick. A
// write takes effect from the next item on.
// An accepted item passes the color RAM read issued at acceptance and the
// read stage registers, then the output register, before it shows on
// rsp_; throughput is one item per cycle while rsp_stall stays low.
// The csr_ channel writes period_ticks, high_ticks_one, high_ticks_zero
// and reset_slots by index; csr_ready is always high. Write it only while
// no item is in flight.
// Reset returns the tick and slot counters to zero, the registers to their
// defaults, and every LED color to 0x00A000 through per-LED valid bits.
// When rsp_stall holds, the output item holds, one more item waits in the
// read stage, and then req_stall rises.
module addressable_led_bit_serializer
   import aled_pkg::*;
#(
   parameter int LED_TOTAL = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [5:0]            req_led_index,
   input  logic [23:0]           req_color,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_line_level,
   output logic                  rsp_slot_start,
   output logic                  rsp_frame_start,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW        = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
   localparam int LED_W     = $clog2(LED_TOTAL + 1);
   localparam int DATA_SLOTS = LED_TOTAL * BITS_PER_LED;
   localparam int SLOT_W    = $clog2(DATA_SLOTS + 257);
   localparam int IDX_W     = (LED_W > 6) ? LED_W : 7;

   logic [TICK_W-1:0] period_ff;
   logic [HIGH_W-1:0] high_one_ff;
   logic [HIGH_W-1:0] high_zero_ff;
   logic [HIGH_W-1:0] reset_slots_ff;

   logic [TICK_W-1:0] tick_ff,  tick_in;
   logic [SLOT_W-1:0] slot_ff,  slot_in;
   logic [LED_W-1:0]  led_ff,   led_in;
   logic [BIT_W-1:0]  bit_ff,   bit_in;

   logic [LED_TOTAL-1:0] known_ff;

   logic              stage_valid_ff;
   logic [TICK_W-1:0] stage_tick_ff;
   logic [BIT_W-1:0]  stage_bit_ff;
   logic              stage_data_ff;
   logic              stage_known_ff;
   logic              stage_slot_start_ff;
   logic              stage_frame_start_ff;

   logic rsp_valid_ff;
   logic line_level_ff;
   logic slot_start_ff;
   logic frame_start_ff;

   logic                    accept;
   logic                    move_stage;
   logic                    out_free;
   logic                    wr_en;
   logic                    data_slot;
   logic                    slot_wrap;
   logic [SLOT_W-1:0]       frame_slots;
   logic [SLOT_W-1:0]       slot_next;
   logic [HIGH_W-1:0]       reset_slots_eff;
   logic [BITS_PER_LED-1:0] ram_color;
   logic [BITS_PER_LED-1:0] color_word;
   logic [HIGH_W-1:0]       high_time;
   logic                    line_level;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= PERIOD_RESET;
         high_one_ff    <= HIGH_ONE_RESET;
         high_zero_ff   <= HIGH_ZERO_RESET;
         reset_slots_ff <= RESET_SLOTS_INIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PERIOD:      period_ff      <= csr_data;
            CSR_HIGH_ONE:    high_one_ff    <= csr_data[HIGH_W-1:0];
            CSR_HIGH_ZERO:   high_zero_ff   <= csr_data[HIGH_W-1:0];
            CSR_RESET_SLOTS: reset_slots_ff <= csr_data[HIGH_W-1:0];
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign move_stage = stage_valid_ff && out_free;
   assign req_stall  = stage_valid_ff && !move_stage;
   assign accept     = req_valid && !req_stall;

   assign wr_en = accept && req_cmd && (IDX_W'(req_led_index) < IDX_W'(LED_TOTAL));

   assign data_slot = (slot_ff != '0) && (slot_ff <= SLOT_W'(DATA_SLOTS));

   always_comb begin
      reset_slots_eff = (reset_slots_ff == '0) ? HIGH_W'(1) : reset_slots_ff;
      frame_slots     = SLOT_W'(DATA_SLOTS) + SLOT_W'(reset_slots_eff);
      slot_next       = slot_ff + SLOT_W'(1);
      slot_wrap       = slot_next >= frame_slots;
      tick_in = tick_ff;
      slot_in = slot_ff;
      led_in  = led_ff;
      bit_in  = bit_ff;
      if (tick_ff >= period_ff) begin
         tick_in = '0;
         if (slot_wrap) begin
            slot_in = '0;
            led_in  = '0;
            bit_in  = BIT_FIRST;
         end else begin
            slot_in = slot_next;
            if (slot_ff != '0) begin
               if (bit_ff == '0) begin
                  bit_in = BIT_FIRST;
                  if (led_ff != LED_W'(LED_TOTAL)) begin
                     led_in = led_ff + LED_W'(1);
                  end
               end else begin
                  bit_in = bit_ff - BIT_W'(1);
               end
            end
         end
      end else begin
         tick_in = tick_ff + TICK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         slot_ff  <= '0;
         led_ff   <= '0;
         bit_ff   <= BIT_FIRST;
         known_ff <= '0;
      end else if (accept) begin
         tick_ff <= tick_in;
         slot_ff <= slot_in;
         led_ff  <= led_in;
         bit_ff  <= bit_in;
         if (wr_en) begin
            known_ff[AW'(req_led_index)] <= 1'b1;
         end
      end
   end

   aled_ram #(
      .WIDTH (BITS_PER_LED),
      .DEPTH (LED_TOTAL)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_led_index)),
      .wr_data (req_color),
      .rd_en   (accept),
      .rd_addr (AW'(led_ff)),
      .rd_data (ram_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (accept) begin
         stage_valid_ff <= 1'b1;
      end else if (move_stage) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_tick_ff        <= tick_ff;
         stage_bit_ff         <= bit_ff;
         stage_data_ff        <= data_slot;
         stage_known_ff       <= data_slot ? known_ff[AW'(led_ff)] : 1'b0;
         stage_slot_start_ff  <= (tick_ff == '0);
         stage_frame_start_ff <= (tick_ff == '0) && (slot_ff == '0);
      end
   end

   always_comb begin
      color_word = stage_known_ff ? ram_color : COLOR_RESET;
      if (!stage_data_ff) begin
         high_time = '0;
      end else if (color_word[stage_bit_ff]) begin
         high_time = high_one_ff;
      end else begin
         high_time = high_zero_ff;
      end
      line_level = stage_tick_ff < TICK_W'(high_time);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move_stage) begin
         line_level_ff  <= line_level;
         slot_start_ff  <= stage_slot_start_ff;
         frame_start_ff <= stage_frame_start_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_level  = line_level_ff;
   assign rsp_slot_start  = slot_start_ff;
   assign rsp_frame_start = frame_start_ff;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the addressable LED bit serializer.
module tb;
   import aled_pkg::*;

   localparam int LED_TOTAL = 64;
   localparam int SLOT_W    = 11;
   localparam int DATA_BITS = LED_TOTAL * BITS_PER_LED;

   typedef struct packed {
      logic                    cmd;
      logic [5:0]              led_index;
      logic [BITS_PER_LED-1:0] color;
   } led_item_type;

   typedef struct packed {
      logic line_level;
      logic slot_start;
      logic frame_start;
   } line_sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd = 1'b0;
   logic [5:0]            req_led_index = '0;
   logic [23:0]           req_color = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_line_level;
   logic                  rsp_slot_start;
   logic                  rsp_frame_start;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [BITS_PER_LED-1:0] led_colors [LED_TOTAL];
   logic [TICK_W-1:0]       tick_cnt = '0;
   logic [SLOT_W-1:0]       slot_cnt = '0;
   logic [TICK_W-1:0]       period_q = PERIOD_RESET;
   logic [HIGH_W-1:0]       one_q = HIGH_ONE_RESET;
   logic [HIGH_W-1:0]       zero_q = HIGH_ZERO_RESET;
   logic [HIGH_W-1:0]       rs_q = RESET_SLOTS_INIT;

   led_item_type    pending_items [$];
   line_sample_type expected_samples [$];

   int mismatch_count = 0;
   int results_seen = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_span = 0;
   int stall_cycle = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;

   addressable_led_bit_serializer #(.LED_TOTAL(LED_TOTAL)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_led_index   (req_led_index),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_level  (rsp_line_level),
      .rsp_slot_start  (rsp_slot_start),
      .rsp_frame_start (rsp_frame_start),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void advance_position(inout logic [TICK_W-1:0] tick,
                                            inout logic [SLOT_W-1:0] slot);
      int frame;
      frame = DATA_BITS + (rs_q == 0 ? 1 : int'(rs_q));
      if (tick >= period_q) begin
         tick = '0;
         slot = (int'(slot) + 1 >= frame) ? '0 : slot + 1'b1;
      end else begin
         tick = tick + 1'b1;
      end
   endfunction

   function automatic logic [HIGH_W-1:0] slot_high_time(logic [SLOT_W-1:0] slot);
      int pos;
      if (slot == 0 || int'(slot) > DATA_BITS)
         return '0;
      pos = int'(slot) - 1;
      return led_colors[pos / BITS_PER_LED][BITS_PER_LED - 1 - pos % BITS_PER_LED] ?
             one_q : zero_q;
   endfunction

   function automatic line_sample_type line_sample_for(led_item_type item);
      line_sample_type s;
      logic [HIGH_W-1:0] high;
      high = slot_high_time(slot_cnt);
      s.line_level  = tick_cnt < high;
      s.slot_start  = tick_cnt == 0;
      s.frame_start = s.slot_start && slot_cnt == 0;
      if (item.cmd)
         led_colors[item.led_index] = item.color;
      advance_position(tick_cnt, slot_cnt);
      return s;
   endfunction

   always @(posedge clock) begin : driver
      logic         accepted;
      led_item_type item;
      accepted = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (accepted) begin
            item = {req_cmd, req_led_index, req_color};
            expected_samples.push_back(line_sample_for(item));
         end
         if (!req_valid || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               item = pending_items.pop_front();
               req_valid     <= 1'b1;
               req_cmd       <= item.cmd;
               req_led_index <= item.led_index;
               req_color     <= item.color;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 32);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      line_sample_type got;
      line_sample_type want;
      logic            stall_next;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_line_level, rsp_slot_start, rsp_frame_start};
         results_seen++;
         if (expected_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("tb: unexpected result at %0t: line %b slot %b frame %b",
                        $time, got.line_level, got.slot_start, got.frame_start);
         end else begin
            want = expected_samples.pop_front();
            if (got.line_level !== want.line_level || got.slot_start !== want.slot_start ||
                got.frame_start !== want.frame_start) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("tb: mismatch at %0t: expected %b%b%b, got %b%b%b",
                           $time, want.line_level, want.slot_start, want.frame_start,
                           got.line_level, got.slot_start, got.frame_start);
            end
         end
      end
      stall_cycle++;
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_span = $urandom_range(16, 96);
      end else begin
         stall_span--;
      end
      if (results_seen >= 150 && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left = 40;
      end
      if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if ($urandom_range(0, 299) == 0) begin
         hold_left = $urandom_range(20, 60);
         stall_next = 1'b1;
      end else begin
         case (stall_mode)
            0: stall_next = 1'b0;
            1: stall_next = $urandom_range(0, 7) == 0;
            2: stall_next = 1'($urandom_range(0, 1));
            default: stall_next = stall_cycle % 3 == 0;
         endcase
      end
      rsp_stall <= reset ? 1'b0 : stall_next;
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_samples.size() != 0);
   endtask

   task automatic run_phase(input int period, input int one, input int zero, input int rs,
                            input int count);
      logic [CSR_DATA_W-1:0] vals [4];
      logic [TICK_W-1:0]     gen_tick;
      logic [SLOT_W-1:0]     gen_slot;
      led_item_type          item;
      vals[CSR_PERIOD]      = CSR_DATA_W'(period);
      vals[CSR_HIGH_ONE]    = CSR_DATA_W'(one);
      vals[CSR_HIGH_ZERO]   = CSR_DATA_W'(zero);
      vals[CSR_RESET_SLOTS] = CSR_DATA_W'(rs);
      wait_idle();
      @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (csr_index_type'(i))
            CSR_PERIOD:      period_q = vals[i];
            CSR_HIGH_ONE:    one_q = vals[i][HIGH_W-1:0];
            CSR_HIGH_ZERO:   zero_q = vals[i][HIGH_W-1:0];
            CSR_RESET_SLOTS: rs_q = vals[i][HIGH_W-1:0];
         endcase
      end
      csr_valid <= 1'b0;
      @(negedge clock);
      gen_tick = tick_cnt;
      gen_slot = slot_cnt;
      repeat (count) begin
         item.cmd = 1'($urandom_range(0, 1));
         if (gen_slot >= 1 && int'(gen_slot) <= DATA_BITS && $urandom_range(0, 1))
            item.led_index = 6'((int'(gen_slot) - 1) / BITS_PER_LED +
                                int'($urandom_range(0, 1)));
         else
            item.led_index = 6'($urandom_range(0, LED_TOTAL - 1));
         case ($urandom_range(0, 7))
            0: item.color = '0;
            1: item.color = '1;
            default: item.color = 24'($urandom());
         endcase
         pending_items.push_back(item);
         advance_position(gen_tick, gen_slot);
      end
   endtask

   initial begin
      foreach (led_colors[i])
         led_colors[i] = COLOR_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      pending_items.push_back({1'b0, 6'd0, 24'h000000});
      pending_items.push_back({1'b1, 6'd0, 24'hFFFFFF});
      pending_items.push_back({1'b1, 6'd63, 24'h000000});
      pending_items.push_back({1'b1, 6'd1, 24'hAAAAAA});
      pending_items.push_back({1'b1, 6'd2, 24'h555555});
      pending_items.push_back({1'b1, 6'd3, 24'h800000});
      pending_items.push_back({1'b1, 6'd4, 24'h000001});
      pending_items.push_back({1'b1, 6'd63, 24'hFFFFFF});
      pending_items.push_back({1'b0, 6'd62, 24'hFFFFFF});
      pending_items.push_back({1'b1, 6'd5, 24'h00A000});
      pending_items.push_back({1'b0, 6'd63, 24'h000000});
      pending_items.push_back({1'b1, 6'd6, 24'h7FFFFE});
      run_phase(3, 2, 1, 50, 48);
      run_phase(0, 255, 0, 50, 250);
      run_phase(7, 9, 3, 50, 80);
      run_phase(1, 1, 0, 255, 120);
      run_phase(0, 1, 0, 255, 350);
      run_phase(0, 0, 1, 0, 350);
      run_phase(2, 0, 255, 1, 60);
      run_phase(65535, 128, 64, 255, 40);
      run_phase(2, 3, 1, 1, 90);
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/aled_pkg.sv
rtl/core/aled_ram.sv
rtl/core/addressable_led_bit_serializer.sv
tb/sv/tb.sv
